@@ rtl/pge_pkg.sv @@
// Shared types and constants for the pixel grayscale and emphasis unit.
`timescale 1ns / 1ps

package pge_pkg;

    localparam int CHAN_W = 8;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } pixel_t;

    localparam chan_t CHAN_MAX = 8'hFF;

    // Emphasis bit positions.
    localparam int EMPH_W     = 3;
    localparam int EMPH_RED   = 0;
    localparam int EMPH_GREEN = 1;
    localparam int EMPH_BLUE  = 2;

    // floor(x / 3) as (x * 683) >> 11, exact for every x below 2048.
    localparam int SUM_W       = CHAN_W + 2;
    localparam int DIV3_RECIP  = 683;
    localparam int DIV3_SHIFT  = 11;
    localparam int DIV3_PROD_W = SUM_W + 10;

endpackage

@@ rtl/pge_gray.sv @@
// Grayscale stage: replaces the colour channels by their truncated mean.
`timescale 1ns / 1ps

module pge_gray (
    input  pge_pkg::pixel_t pix_in,
    input  logic            gray_enable,
    output pge_pkg::pixel_t pix_out
);

    logic [pge_pkg::SUM_W-1:0]       sum;
    logic [pge_pkg::DIV3_PROD_W-1:0] prod;
    pge_pkg::chan_t                  avg;

    always_comb
    begin
        sum  = pge_pkg::SUM_W'(pix_in.red) + pge_pkg::SUM_W'(pix_in.green)
             + pge_pkg::SUM_W'(pix_in.blue);
        prod = pge_pkg::DIV3_PROD_W'(sum) * pge_pkg::DIV3_PROD_W'(pge_pkg::DIV3_RECIP);
        avg  = prod[pge_pkg::DIV3_SHIFT +: pge_pkg::CHAN_W];

        pix_out = pix_in;
        if (gray_enable)
        begin
            pix_out.red   = avg;
            pix_out.green = avg;
            pix_out.blue  = avg;
        end
    end

endmodule

@@ rtl/pge_emph.sv @@
// Emphasis stage: scales each channel by its combined factor and saturates; alpha goes to 255 under any emphasis.
`timescale 1ns / 1ps

module pge_emph #(
    parameter int FACTOR_FRAC_BITS = 24
) (
    input  pge_pkg::pixel_t                    pix_in,
    input  logic [pge_pkg::EMPH_W-1:0]         emphasis,
    output pge_pkg::pixel_t                    pix_out
);

    localparam int FACTOR_W = FACTOR_FRAC_BITS + 1;
    localparam int PROD_W   = FACTOR_W + pge_pkg::CHAN_W;

    // Factors n/d held as ceil(n * 2^F / d), so that exact products stay exact.
    localparam logic [FACTOR_W-1:0] F_0_9   =
        FACTOR_W'(((64'd9 << FACTOR_FRAC_BITS) + 64'd9) / 64'd10);
    localparam logic [FACTOR_W-1:0] F_0_81  =
        FACTOR_W'(((64'd81 << FACTOR_FRAC_BITS) + 64'd99) / 64'd100);
    localparam logic [FACTOR_W-1:0] F_1_1   =
        FACTOR_W'(((64'd11 << FACTOR_FRAC_BITS) + 64'd9) / 64'd10);
    localparam logic [FACTOR_W-1:0] F_0_99  =
        FACTOR_W'(((64'd99 << FACTOR_FRAC_BITS) + 64'd99) / 64'd100);
    localparam logic [FACTOR_W-1:0] F_0_891 =
        FACTOR_W'(((64'd891 << FACTOR_FRAC_BITS) + 64'd999) / 64'd1000);
    localparam logic [FACTOR_W-1:0] F_ONE   = FACTOR_W'(64'd1 << FACTOR_FRAC_BITS);

    pge_pkg::chan_t chan_in  [3];
    pge_pkg::chan_t chan_out [3];

    assign chan_in[pge_pkg::EMPH_RED]   = pix_in.red;
    assign chan_in[pge_pkg::EMPH_GREEN] = pix_in.green;
    assign chan_in[pge_pkg::EMPH_BLUE]  = pix_in.blue;

    for (genvar g = 0; g < 3; g++)
    begin : g_chan
        localparam int OTHER_A = (g + 1) % 3;
        localparam int OTHER_B = (g + 2) % 3;

        logic [1:0]          others;
        logic [FACTOR_W-1:0] factor;
        logic [PROD_W-1:0]   prod;

        always_comb
        begin
            others = 2'(emphasis[OTHER_A]) + 2'(emphasis[OTHER_B]);
            case ({emphasis[g], others})
                3'b0_01: factor = F_0_9;
                3'b0_10: factor = F_0_81;
                3'b1_00: factor = F_1_1;
                3'b1_01: factor = F_0_99;
                3'b1_10: factor = F_0_891;
                default: factor = F_ONE;
            endcase
            prod = PROD_W'(chan_in[g]) * PROD_W'(factor);
            // Only the 1.1 factors can push the integer part past 255.
            if (prod[PROD_W-1])
                chan_out[g] = pge_pkg::CHAN_MAX;
            else
                chan_out[g] = prod[FACTOR_FRAC_BITS +: pge_pkg::CHAN_W];
        end
    end

    always_comb
    begin
        pix_out = pix_in;
        if (emphasis != '0)
        begin
            pix_out.red   = chan_out[pge_pkg::EMPH_RED];
            pix_out.green = chan_out[pge_pkg::EMPH_GREEN];
            pix_out.blue  = chan_out[pge_pkg::EMPH_BLUE];
            pix_out.alpha = pge_pkg::CHAN_MAX;
        end
    end

endmodule

@@ rtl/pixel_grayscale_emphasis_unit.sv @@
// Top level of the pixel grayscale and colour emphasis unit.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------------------
//   input    | start, busy        | in_red, in_green, in_blue, in_alpha,
//            |                    | gray_enable, emphasis, line_end_in
//   result   | done (one cycle)   | out_red, out_green, out_blue, out_alpha,
//            |                    | line_end_out
//
// One pixel is taken per clock; busy is never raised.
// A result passes through the input register and then the result register: the grayscale mean is
// formed ahead of the input register and the emphasis multiply ahead of the
// result register, one multiplier per channel between the two.
// Reset clears the valid flags of both registers; no result is shown until
// a transaction has passed through. The receiver cannot stall the stream.
`timescale 1ns / 1ps

module pixel_grayscale_emphasis_unit #(
    parameter int FACTOR_FRAC_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,
    input  logic       gray_enable,
    input  logic [2:0] emphasis,
    input  logic       line_end_in,
    output logic       done,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       line_end_out
);

    pge_pkg::pixel_t                   raw_pix;
    pge_pkg::pixel_t                   s1_pix_next;
    pge_pkg::pixel_t                   s1_pix_reg;
    logic [pge_pkg::EMPH_W-1:0]        s1_emph_reg;
    logic                              s1_le_reg;
    logic                              s1_valid_reg;
    logic                              s1_valid_next;

    pge_pkg::pixel_t                   res_pix_next;
    pge_pkg::pixel_t                   res_pix_reg;
    logic                              res_le_reg;
    logic                              res_valid_reg;

    assign busy          = 1'b0;
    assign s1_valid_next = start && !busy;

    assign raw_pix = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

    pge_gray u_gray (
        .pix_in      (raw_pix),
        .gray_enable (gray_enable),
        .pix_out     (s1_pix_next)
    );

    pge_emph #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_emph (
        .pix_in   (s1_pix_reg),
        .emphasis (s1_emph_reg),
        .pix_out  (res_pix_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_pix_reg  <= s1_pix_next;
            s1_emph_reg <= emphasis;
            s1_le_reg   <= line_end_in;
        end
        if (s1_valid_reg)
        begin
            res_pix_reg <= res_pix_next;
            res_le_reg  <= s1_le_reg;
        end
    end

    assign done         = res_valid_reg;
    assign out_red      = res_pix_reg.red;
    assign out_green    = res_pix_reg.green;
    assign out_blue     = res_pix_reg.blue;
    assign out_alpha    = res_pix_reg.alpha;
    assign line_end_out = res_le_reg;

endmodule

@@ rtl/pge_checker.sv @@
// Port-level checks for the pixel grayscale and emphasis unit, with its bind.
`timescale 1ns / 1ps

module pge_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] in_alpha,
    input logic       gray_enable,
    input logic [2:0] emphasis,
    input logic       line_end_in,
    input logic       done,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       line_end_out
);

    // Every result belongs to a transaction that has passed through both registers.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching transaction");

    a_transaction_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("transaction produced no result");

    // Grayscale without emphasis leaves three equal channels and the alpha.
    a_gray_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && gray_enable && emphasis == 3'd0) |-> ##2
        (out_red == out_green && out_green == out_blue
         && out_alpha == $past(in_alpha, 2)))
        else $error("grayscale result inconsistent");

    a_emph_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && emphasis != 3'd0) |-> ##2 (out_alpha == pge_pkg::CHAN_MAX))
        else $error("alpha not forced under emphasis");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 (line_end_out == $past(line_end_in, 2)))
        else $error("end-of-line mark not carried");

endmodule

bind pixel_grayscale_emphasis_unit pge_checker u_pge_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the pixel grayscale and colour emphasis unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int FACTOR_FRAC_BITS = 24;
    localparam int GAIN_UP          = 11;
    localparam int GAIN_DOWN        = 9;
    localparam int GAIN_DEN         = 10;
    localparam int IDLE_PERCENT     = 29;
    localparam int RANDOM_PIXELS    = 1630;
    localparam int MAX_REPORTS      = 10;

    localparam logic [pge_pkg::EMPH_W-1:0] EMPH_NONE = '0;
    localparam logic [pge_pkg::EMPH_W-1:0] EMPH_R    =
        pge_pkg::EMPH_W'(1 << pge_pkg::EMPH_RED);
    localparam logic [pge_pkg::EMPH_W-1:0] EMPH_G    =
        pge_pkg::EMPH_W'(1 << pge_pkg::EMPH_GREEN);
    localparam logic [pge_pkg::EMPH_W-1:0] EMPH_B    =
        pge_pkg::EMPH_W'(1 << pge_pkg::EMPH_BLUE);

    typedef struct packed {
        pge_pkg::pixel_t px;
        logic            line_end;
    } shaded_pixel_t;

    class pixel_scoreboard;
        shaded_pixel_t expected_q[$];
        int unsigned   errors;

        function longint unsigned emphasis_gain(int own, logic [pge_pkg::EMPH_W-1:0] emph);
            longint unsigned num;
            longint unsigned den;
            num = 1;
            den = 1;
            for (int k = 0; k < pge_pkg::EMPH_W; k++)
            begin
                if (emph[k])
                begin
                    num *= (k == own) ? GAIN_UP : GAIN_DOWN;
                    den *= GAIN_DEN;
                end
            end
            // The gain is rounded up so that exact decimal products stay exact.
            return ((num << FACTOR_FRAC_BITS) + den - 1) / den;
        endfunction

        function pge_pkg::chan_t scale_channel(pge_pkg::chan_t c, longint unsigned gain);
            longint unsigned prod;
            prod = 64'(c);
            prod = (prod * gain) >> FACTOR_FRAC_BITS;
            return (prod > pge_pkg::CHAN_MAX) ? pge_pkg::CHAN_MAX : pge_pkg::chan_t'(prod);
        endfunction

        function void note_pixel(pge_pkg::pixel_t px, logic gray,
                                 logic [pge_pkg::EMPH_W-1:0] emph, logic line_end);
            shaded_pixel_t  want;
            int unsigned    sum;
            pge_pkg::chan_t mean;
            want.px = px;
            if (gray)
            begin
                sum  = 32'(px.red) + 32'(px.green) + 32'(px.blue);
                mean = pge_pkg::chan_t'(sum / 3);
                want.px.red   = mean;
                want.px.green = mean;
                want.px.blue  = mean;
            end
            if (emph != EMPH_NONE)
            begin
                want.px.red   = scale_channel(want.px.red,
                                              emphasis_gain(pge_pkg::EMPH_RED, emph));
                want.px.green = scale_channel(want.px.green,
                                              emphasis_gain(pge_pkg::EMPH_GREEN, emph));
                want.px.blue  = scale_channel(want.px.blue,
                                              emphasis_gain(pge_pkg::EMPH_BLUE, emph));
                want.px.alpha = pge_pkg::CHAN_MAX;
            end
            want.line_end = line_end;
            expected_q.push_back(want);
        endfunction

        function void check_pixel(shaded_pixel_t got);
            shaded_pixel_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d le=%0b",
                             $realtime, got.px.red, got.px.green, got.px.blue,
                             got.px.alpha, got.line_end);
                return;
            end
            want = expected_q.pop_front();
            if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
                got.px.blue !== want.px.blue || got.px.alpha !== want.px.alpha ||
                got.line_end !== want.line_end)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d le=%0b",
                              " actual r=%0d g=%0d b=%0d a=%0d le=%0b"}, $realtime,
                             want.px.red, want.px.green, want.px.blue, want.px.alpha,
                             want.line_end, got.px.red, got.px.green, got.px.blue,
                             got.px.alpha, got.line_end);
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [7:0]                 in_red;
    logic [7:0]                 in_green;
    logic [7:0]                 in_blue;
    logic [7:0]                 in_alpha;
    logic                       gray_enable;
    logic [pge_pkg::EMPH_W-1:0] emphasis;
    logic                       line_end_in;
    logic                       done;
    logic [7:0]                 out_red;
    logic [7:0]                 out_green;
    logic [7:0]                 out_blue;
    logic [7:0]                 out_alpha;
    logic                       line_end_out;

    bit                         idle_on = 1'b1;
    pixel_scoreboard            sb = new();

    pixel_grayscale_emphasis_unit #(
        .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_alpha     (in_alpha),
        .gray_enable  (gray_enable),
        .emphasis     (emphasis),
        .line_end_in  (line_end_in),
        .done         (done),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .line_end_out (line_end_out)
    );

    always #10 clk = ~clk;

    // Inputs are noted before results are checked, so that a short pipeline
    // still finds its expectation queued.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (start && !busy)
                sb.note_pixel({in_red, in_green, in_blue, in_alpha}, gray_enable,
                              emphasis, line_end_in);
            if (done)
                sb.check_pixel({out_red, out_green, out_blue, out_alpha, line_end_out});
        end
    end

    task automatic send_pixel(pge_pkg::chan_t r, pge_pkg::chan_t g, pge_pkg::chan_t b,
                              pge_pkg::chan_t a, logic gray,
                              logic [pge_pkg::EMPH_W-1:0] emph, logic line_end);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        in_red      <= r;
        in_green    <= g;
        in_blue     <= b;
        in_alpha    <= a;
        gray_enable <= gray;
        emphasis    <= emph;
        line_end_in <= line_end;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Biased towards the ends of the range, where saturation and zero live.
    function automatic pge_pkg::chan_t pick_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return pge_pkg::CHAN_MAX;
            2:       return pge_pkg::chan_t'($urandom_range(225, 255));
            default: return pge_pkg::chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        in_red      <= '0;
        in_green    <= '0;
        in_blue     <= '0;
        in_alpha    <= '0;
        gray_enable <= 1'b0;
        emphasis    <= EMPH_NONE;
        line_end_in <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, EMPH_NONE, 1'b0);
        send_pixel(pge_pkg::CHAN_MAX, pge_pkg::CHAN_MAX, pge_pkg::CHAN_MAX,
                   pge_pkg::CHAN_MAX, 1'b1, EMPH_NONE, 1'b1);
        for (int e = 1; e < 8; e++)
            send_pixel(pge_pkg::CHAN_MAX, pge_pkg::CHAN_MAX, pge_pkg::CHAN_MAX, 8'h5A,
                       1'b0, pge_pkg::EMPH_W'(e), e[0]);
        for (int e = 0; e < 8; e++)
            send_pixel(8'd200, 8'd100, 8'd50, 8'hA5, 1'b1, pge_pkg::EMPH_W'(e), ~e[0]);
        // Red at 233 saturates under its own emphasis; green at 232 is only scaled down by 0.9.
        send_pixel(8'd233, 8'd232, 8'd10, 8'd0, 1'b0, EMPH_R, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd0, 8'd7, 1'b1, EMPH_NONE, 1'b0);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd1, 1'b0, EMPH_G | EMPH_B, 1'b1);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            idle_on = !(i >= 600 && i < 900);
            send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
                       1'($urandom_range(0, 1)), pge_pkg::EMPH_W'($urandom_range(0, 7)),
                       ($urandom_range(0, 7) == 0));
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
